// File: sv/amai_pkg.sv
// Package for the affine matrix inverse core: widths, cofactor index tables,
// item structs and the shared saturation function.
// No dependencies; every other file uses it by scoped names.
package amai_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS   = 16;
    localparam int A_W         = 32;
    localparam int NUM_IN      = 12;
    localparam int NUM_ELEM    = 12;
    localparam int IDX_W       = 4;
    localparam int FLOOR_W     = 31;
    localparam int IN_TDATA_W  = NUM_IN * A_W;
    localparam int OUT_FIELD_W = A_W + 4;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Arithmetic widths
    localparam int PROD_W = 2 * A_W;            // 32x32 product
    localparam int ADJ_W  = 2 * A_W;            // cofactor fits 64 bits signed
    localparam int DET_W  = ADJ_W + A_W + 1;    // determinant, signed
    localparam int MAG_W  = DET_W - 1;          // determinant magnitude
    localparam int Q_BITS = A_W + 1;            // quotient bits before saturation
    localparam int N_W    = ADJ_W + 2 * FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_ELEM - 1);
    localparam logic [1:0]       TRANS_COL = 2'd3;

    // Cofactor k = row*3+col is +/-(a[P]*a[Q] - a[R]*a[S]); a index = row*4+col
    localparam logic [3:0] XP [9] = '{4'd5, 4'd1, 4'd1, 4'd4, 4'd0, 4'd0, 4'd4, 4'd0, 4'd0};
    localparam logic [3:0] XQ [9] = '{4'd10, 4'd10, 4'd6, 4'd10, 4'd10, 4'd6, 4'd9, 4'd9, 4'd5};
    localparam logic [3:0] XR [9] = '{4'd9, 4'd9, 4'd5, 4'd8, 4'd8, 4'd4, 4'd8, 4'd8, 4'd4};
    localparam logic [3:0] XS [9] = '{4'd6, 4'd2, 4'd2, 4'd6, 4'd2, 4'd2, 4'd5, 4'd1, 4'd1};
    localparam logic [8:0] XNEG   = 9'h0AA;

    // One matrix after determinant and floor check
    typedef struct packed {
        logic [8:0][ADJ_W-1:0] adj;
        logic [2:0][A_W-1:0]   tr;
        logic [MAG_W-1:0]      dmag;
        logic                  dneg;
        logic                  sing;
    } mat_t;

    // One result slot entering the divider
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic                sing;
        logic                last;
        logic [ADJ_W-1:0]    adj;
        logic [MAG_W-1:0]    dmag;
        logic                dneg;
        logic [2:0][A_W-1:0] tr;
    } slot_t;

    // Divider stage contents
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic                sing;
        logic                last;
        logic                neg;
        logic                ovf;
        logic [Q_BITS-1:0]   nlow;
        logic [MAG_W-1:0]    rem;
        logic [MAG_W-1:0]    dmag;
        logic [Q_BITS-1:0]   q;
        logic [2:0][A_W-1:0] tr;
    } dstep_t;

    // Divider result
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic                sing;
        logic                last;
        logic [A_W-1:0]      value;
        logic [2:0][A_W-1:0] tr;
    } res_t;

    // Signed saturation of a magnitude with sign to one Q16.16 word
    function automatic logic [A_W-1:0] sat_word(input logic [SUM_W-1:0] mag,
                                                input logic neg);
        logic [SUM_W-1:0] lim;
        logic [A_W-1:0]   res;
        lim = neg ? (SUM_W'(1) << (A_W - 1)) : ((SUM_W'(1) << (A_W - 1)) - SUM_W'(1));
        if (mag > lim) begin
            res = neg ? {1'b1, {(A_W-1){1'b0}}} : {1'b0, {(A_W-1){1'b1}}};
        end else begin
            res = neg ? (A_W'(0) - mag[A_W-1:0]) : mag[A_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: sv/affine_matrix_inverse_core.sv
// Top level of the affine matrix inverse core: config register, stall
// enables and the chain front -> serializer -> divider -> translation.
// Depends on amai_pkg and all amai_* modules.
//
// Usage:
//  - s_ channel: one item is the top three rows of an affine 4x4 matrix,
//    twelve signed Q16.16 entries, a00 in the lowest bits of s_tdata.
//  - m_ channel: twelve items per matrix in row order (columns 0..3, column 3
//    the translation), m_tlast on the twelfth. A matrix whose determinant
//    magnitude is at or below det_floor gives one item, m_tuser high,
//    value zero, m_tlast high.
//  - cfg_we/cfg_wdata write det_floor (Q16.16); write only while idle.
//  - The single result port sets the pace: twelve items per matrix (one
//    for a singular one). The front end holds the next matrix and s_tready
//    drops while the serializer drains. All other stages take an item
//    every cycle unless m_tready stalls them, with a 33-stage divider
//    doing one quotient bit a stage.
//  - Reset clears all valid bits and det_floor; nothing needs clearing.
//  - When m_tready is low the pipeline holds (the front end once its output
//    is valid); the output register keeps its item; nothing is lost or repeated.
module affine_matrix_inverse_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [amai_pkg::FLOOR_W-1:0]        cfg_wdata,    // det_floor
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [amai_pkg::IN_TDATA_W-1:0]     s_tdata,      // a00,a01,a02,a03,a10..a23
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [amai_pkg::OUT_TDATA_W-1:0]    m_tdata,      // elem_value,elem_row,elem_col
    output logic                                m_tuser,      // singular
    output logic                                m_tlast       // last
);
    logic [amai_pkg::FLOOR_W-1:0] floor_reg;
    logic                         en;
    logic                         fen;
    logic                         f_valid;
    amai_pkg::mat_t               f_mat;
    logic                         take;
    logic                         slot_valid;
    amai_pkg::slot_t              slot;
    logic                         res_valid;
    amai_pkg::res_t               res;
    logic [amai_pkg::A_W-1:0]     o_value;
    logic [1:0]                   o_row;
    logic [1:0]                   o_col;

    // det_floor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= '0;
        end else if (cfg_we) begin
            floor_reg <= cfg_wdata;
        end
    end

    // Stall enables
    assign en       = !m_tvalid || m_tready;
    assign fen      = !f_valid || take;
    assign s_tready = fen;

    amai_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (fen),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .floor_val (floor_reg),
        .out_valid (f_valid),
        .out_mat   (f_mat)
    );

    amai_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (f_valid),
        .in_mat     (f_mat),
        .take       (take),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    amai_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .slot_valid (slot_valid),
        .slot       (slot),
        .res_valid  (res_valid),
        .res        (res)
    );

    amai_trans u_trans (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (m_tvalid),
        .out_value (o_value),
        .out_row   (o_row),
        .out_col   (o_col),
        .out_sing  (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = amai_pkg::OUT_TDATA_W'({o_col, o_row, o_value});

    // A singular item is alone: it closes its matrix
    a_sing_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("singular item without last");

    // A singular item carries zero value at row 0, column 0
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[35:0] == 36'd0)
        else $error("singular item not zero");

    // A regular burst ends on the row 2 translation entry
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata[33:32] == 2'd2 && m_tdata[35:34] == 2'd3)
        else $error("last flag at wrong entry");

    // Row 3 never appears
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("row out of range");

endmodule

// File: sv/amai_front.sv
// Matrix front end: cofactors, determinant and singular check in seven stages.
// Depends on amai_pkg.
module amai_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [amai_pkg::IN_TDATA_W-1:0]  in_data,
    input  logic [amai_pkg::FLOOR_W-1:0]     floor_val,
    output logic                             out_valid,
    output amai_pkg::mat_t                   out_mat
);
    localparam int A_W   = amai_pkg::A_W;
    localparam int PW    = amai_pkg::PROD_W;
    localparam int AW    = amai_pkg::ADJ_W;
    localparam int DW    = amai_pkg::DET_W;
    localparam int MW    = amai_pkg::MAG_W;

    logic [6:0] v_reg;

    logic        [A_W-1:0] a1_reg [12];
    logic signed [PW-1:0]  pp_reg [9];
    logic signed [PW-1:0]  pn_reg [9];
    logic signed [AW-1:0]  adj3_reg [9];
    logic signed [AW-1:0]  adj4_reg [9];
    logic signed [AW-1:0]  adj5_reg [9];
    logic signed [AW-1:0]  adj6_reg [9];
    logic        [A_W-1:0] a02_reg [3];
    logic        [A_W-1:0] a03_reg [3];
    logic        [A_W-1:0] tr2_reg [3];
    logic        [A_W-1:0] tr3_reg [3];
    logic        [A_W-1:0] tr4_reg [3];
    logic        [A_W-1:0] tr5_reg [3];
    logic        [A_W-1:0] tr6_reg [3];
    logic signed [PW-1:0]  ph_reg [3];
    logic signed [PW:0]    pl_reg [3];
    logic signed [DW-1:0]  t_reg [3];
    logic signed [DW-1:0]  det_reg;
    amai_pkg::mat_t        mat_reg;
    amai_pkg::mat_t        mat_next;

    logic [DW-1:0] det_abs;
    logic          sing_next;

    // Valid bits travel with the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // Floor check on the determinant magnitude, final stage contents
    always_comb begin
        det_abs   = det_reg[DW-1] ? (DW'(0) - det_reg) : det_reg;
        sing_next = det_abs[MW-1:0] <=
                    MW'({floor_val, {(2 * amai_pkg::FRAC_BITS){1'b0}}});
        for (int k = 0; k < 9; k++) begin
            mat_next.adj[k] = adj6_reg[k];
        end
        for (int j = 0; j < 3; j++) begin
            mat_next.tr[j] = tr6_reg[j];
        end
        mat_next.dmag = det_abs[MW-1:0];
        mat_next.dneg = det_reg[DW-1];
        mat_next.sing = sing_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: capture entries
            for (int i = 0; i < 12; i++) begin
                a1_reg[i] <= in_data[i*A_W +: A_W];
            end
            // stage 2: cross products
            for (int k = 0; k < 9; k++) begin
                pp_reg[k] <= $signed(a1_reg[amai_pkg::XP[k]]) * $signed(a1_reg[amai_pkg::XQ[k]]);
                pn_reg[k] <= $signed(a1_reg[amai_pkg::XR[k]]) * $signed(a1_reg[amai_pkg::XS[k]]);
            end
            for (int j = 0; j < 3; j++) begin
                a02_reg[j] <= a1_reg[j];
                tr2_reg[j] <= a1_reg[4*j+3];
            end
            // stage 3: cofactors
            for (int k = 0; k < 9; k++) begin
                adj3_reg[k] <= amai_pkg::XNEG[k] ? (pn_reg[k] - pp_reg[k])
                                                 : (pp_reg[k] - pn_reg[k]);
            end
            a03_reg <= a02_reg;
            tr3_reg <= tr2_reg;
            // stage 4: determinant partial products, cofactor split in halves
            for (int j = 0; j < 3; j++) begin
                ph_reg[j] <= $signed(a03_reg[j]) * $signed(adj3_reg[3*j][AW-1:A_W]);
                pl_reg[j] <= $signed(a03_reg[j]) * $signed({1'b0, adj3_reg[3*j][A_W-1:0]});
            end
            adj4_reg <= adj3_reg;
            tr4_reg  <= tr3_reg;
            // stage 5: recombine halves
            for (int j = 0; j < 3; j++) begin
                t_reg[j] <= DW'($signed({ph_reg[j], {A_W{1'b0}}})) + DW'(pl_reg[j]);
            end
            adj5_reg <= adj4_reg;
            tr5_reg  <= tr4_reg;
            // stage 6: determinant
            det_reg  <= t_reg[0] + t_reg[1] + t_reg[2];
            adj6_reg <= adj5_reg;
            tr6_reg  <= tr5_reg;
            // stage 7: magnitude, sign, floor check
            mat_reg <= mat_next;
        end
    end

    assign out_valid = v_reg[6];
    assign out_mat   = mat_reg;

endmodule

// File: sv/amai_serial.sv
// Serializer: holds one matrix and issues its result slots one per cycle when en is high.
// Depends on amai_pkg.
module amai_serial (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  amai_pkg::mat_t in_mat,
    output logic           take,
    output logic           slot_valid,
    output amai_pkg::slot_t slot
);
    localparam int IW = amai_pkg::IDX_W;

    logic                busy_reg;
    logic [IW-1:0]       cnt_reg;
    logic                slot_v_reg;
    amai_pkg::mat_t      mat_reg;
    amai_pkg::slot_t     slot_reg;
    amai_pkg::slot_t     slot_next;
    logic                last_slot;
    logic [1:0]          row;
    logic [1:0]          col;
    logic [3:0]          aidx;

    // Slot contents for the current count
    always_comb begin
        last_slot = mat_reg.sing || (cnt_reg == amai_pkg::LAST_IDX);
        take      = en && (!busy_reg || last_slot);
        row       = cnt_reg[3:2];
        col       = cnt_reg[1:0];
        aidx      = {2'b00, row} * 4'd3 + {2'b00, col};
        slot_next.idx  = mat_reg.sing ? '0 : cnt_reg;
        slot_next.sing = mat_reg.sing;
        slot_next.last = last_slot;
        slot_next.adj  = (col == amai_pkg::TRANS_COL) ? '0 : mat_reg.adj[aidx];
        slot_next.dmag = mat_reg.dmag;
        slot_next.dneg = mat_reg.dneg;
        slot_next.tr   = mat_reg.tr;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            slot_v_reg <= 1'b0;
        end else if (en) begin
            slot_v_reg <= busy_reg;
            if (take) begin
                busy_reg <= in_valid;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
            if (take) begin
                mat_reg <= in_mat;
            end
        end
    end

    assign slot_valid = slot_v_reg;
    assign slot       = slot_reg;

endmodule

// File: sv/amai_div.sv
// Pipelined restoring divider: one quotient bit per stage, then rounding
// and saturation. Depends on amai_pkg.
module amai_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            slot_valid,
    input  amai_pkg::slot_t slot,
    output logic            res_valid,
    output amai_pkg::res_t  res
);
    localparam int QB = amai_pkg::Q_BITS;
    localparam int MW = amai_pkg::MAG_W;
    localparam int AW = amai_pkg::ADJ_W;
    localparam int NW = amai_pkg::N_W;
    localparam int SW = amai_pkg::SUM_W;

    logic [QB:0]       sv_reg;
    amai_pkg::dstep_t  st_reg [QB+1];
    amai_pkg::dstep_t  init_next;
    logic [AW-1:0]     mag;
    logic [NW-1:0]     num;
    amai_pkg::res_t    res_reg;
    amai_pkg::res_t    res_next;
    logic              res_v_reg;
    logic              rnd;
    logic [SW-1:0]     qr;

    // Entry: numerator magnitude, overflow check, first partial remainder
    always_comb begin
        mag = slot.adj[AW-1] ? (AW'(0) - slot.adj) : slot.adj;
        num = {mag, {(2 * amai_pkg::FRAC_BITS){1'b0}}};
        init_next.idx  = slot.idx;
        init_next.sing = slot.sing;
        init_next.last = slot.last;
        init_next.neg  = slot.adj[AW-1] ^ slot.dneg;
        init_next.nlow = num[QB-1:0];
        init_next.rem  = MW'(num[NW-1:QB]);
        init_next.ovf  = MW'(num[NW-1:QB]) >= slot.dmag;
        init_next.dmag = slot.dmag;
        init_next.q    = '0;
        init_next.tr   = slot.tr;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= init_next;
        end
    end

    // Quotient bit stages
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [MW:0]      sh;
        logic             ge;
        amai_pkg::dstep_t step_next;
        always_comb begin
            sh = {st_reg[k].rem, st_reg[k].nlow[QB-1-k]};
            ge = sh >= {1'b0, st_reg[k].dmag};
            step_next     = st_reg[k];
            step_next.rem = ge ? MW'(sh - {1'b0, st_reg[k].dmag}) : sh[MW-1:0];
            step_next.q   = {st_reg[k].q[QB-2:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= step_next;
            end
        end
    end

    // Round to nearest, ties away, then saturate
    always_comb begin
        rnd = {st_reg[QB].rem, 1'b0} >= {1'b0, st_reg[QB].dmag};
        qr  = SW'(st_reg[QB].q) + SW'(rnd);
        res_next.idx   = st_reg[QB].idx;
        res_next.sing  = st_reg[QB].sing;
        res_next.last  = st_reg[QB].last;
        res_next.tr    = st_reg[QB].tr;
        res_next.value = st_reg[QB].sing ? '0 :
                         amai_pkg::sat_word(st_reg[QB].ovf ? '1 : qr, st_reg[QB].neg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg    <= '0;
            res_v_reg <= 1'b0;
        end else if (en) begin
            sv_reg    <= {sv_reg[QB-1:0], slot_valid};
            res_v_reg <= sv_reg[QB];
        end
    end

    assign res_valid = res_v_reg;
    assign res       = res_reg;

endmodule

// File: sv/amai_trans.sv
// Translation column: captures a row's inverse entries, forms the negated
// dot product with the translation, rounds and saturates. Depends on amai_pkg.
module amai_trans (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       res_valid,
    input  amai_pkg::res_t             res,
    output logic                       out_valid,
    output logic [amai_pkg::A_W-1:0]   out_value,
    output logic [1:0]                 out_row,
    output logic [1:0]                 out_col,
    output logic                       out_sing,
    output logic                       out_last
);
    localparam int A_W = amai_pkg::A_W;
    localparam int PW  = amai_pkg::PROD_W;
    localparam int SW  = amai_pkg::SUM_W;
    localparam int F   = amai_pkg::FRAC_BITS;
    localparam int IW  = amai_pkg::IDX_W;

    typedef struct packed {
        logic [IW-1:0]  idx;
        logic           sing;
        logic           last;
        logic [A_W-1:0] value;
    } elem_t;

    logic [2:0]            v_reg;
    logic [A_W-1:0]        inv_reg [3];
    elem_t                 e1_reg;
    elem_t                 e2_reg;
    elem_t                 e3_reg;
    elem_t                 e3_next;
    logic signed [PW-1:0]  p_reg [3];
    logic signed [SW-1:0]  s_reg;
    logic signed [SW-1:0]  sum;
    logic                  sneg;
    logic [SW-1:0]         smag;
    logic [SW-1:0]         rmag;
    logic [A_W-1:0]        tval;

    always_comb begin
        sum  = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(p_reg[2]);
        sneg = s_reg[SW-1];
        smag = sneg ? (SW'(0) - s_reg) : s_reg;
        rmag = (smag + (SW'(1) << (F - 1))) >> F;
        tval = amai_pkg::sat_word(rmag, sneg);
        // translation slot takes the rounded dot product
        e3_next = e2_reg;
        if (e2_reg.idx[1:0] == amai_pkg::TRANS_COL && !e2_reg.sing) begin
            e3_next.value = tval;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // hold this row's inverse entries for the translation slot
            if (res_valid && !res.sing && res.idx[1:0] != amai_pkg::TRANS_COL) begin
                inv_reg[res.idx[1:0]] <= res.value;
            end
            // stage 1: products
            e1_reg <= '{idx: res.idx, sing: res.sing, last: res.last, value: res.value};
            for (int j = 0; j < 3; j++) begin
                p_reg[j] <= $signed(res.tr[j]) * $signed(inv_reg[j]);
            end
            // stage 2: negated sum
            e2_reg <= e1_reg;
            s_reg  <= SW'(0) - sum;
            // stage 3: round and pick
            e3_reg <= e3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], res_valid};
        end
    end

    assign out_valid = v_reg[2];
    assign out_value = e3_reg.value;
    assign out_row   = e3_reg.idx[3:2];
    assign out_col   = e3_reg.idx[1:0];
    assign out_sing  = e3_reg.sing;
    assign out_last  = e3_reg.last;

endmodule

// File: bench/testbench.sv
// Testbench for affine_matrix_inverse_core: random and directed 3x4 affine matrices,
// each checked against an inverse predictor with exact wide integer arithmetic.
// Depends on amai_pkg and the core's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        sing;
        logic        last;
    } elem_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [amai_pkg::FLOOR_W-1:0]     cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [amai_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [amai_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;

    logic [amai_pkg::IN_TDATA_W-1:0] matrix_queue[$];
    elem_t                           expected_elems[$];
    logic [amai_pkg::FLOOR_W-1:0]    floor_model = '0;
    int                    mismatches = 0;
    int                    idle_cycles = 0;
    int                    matrices_sent = 0;
    int                    elems_seen = 0;
    int                    singular_seen = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;
    int                    stall_run = 0;
    bit                    hold_sink = 1'b0;
    bit                    sender_paused = 1'b0;
    bit                    timed_out = 1'b0;
    bit                    in_taken = 1'b0;

    affine_matrix_inverse_core u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Round magnitude / divisor to nearest, ties away, saturate to 32 bits
    function automatic logic [31:0] clamp_word(logic signed [255:0] v);
        if (v > 256'sd2147483647) return 32'h7FFFFFFF;
        if (v < -256'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [255:0] round_div(logic signed [255:0] num,
                                                      logic signed [255:0] den);
        logic signed [255:0] n, d, q, r;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n - q * d;
        if (2 * r >= d) q = q + 1;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Predict the result items for one matrix
    task automatic predict_inverse(input logic [amai_pkg::IN_TDATA_W-1:0] m);
        logic signed [255:0] a[12];
        logic signed [255:0] adj[9];
        logic signed [255:0] det, adet, sum;
        logic signed [255:0] inv[9];
        logic [31:0]         word[12];
        elem_t               e;
        for (int i = 0; i < 12; i++) a[i] = $signed(m[i*32 +: 32]);
        adj[0] = a[5]*a[10] - a[9]*a[6];
        adj[1] = -(a[1]*a[10] - a[9]*a[2]);
        adj[2] = a[1]*a[6] - a[5]*a[2];
        adj[3] = -(a[4]*a[10] - a[8]*a[6]);
        adj[4] = a[0]*a[10] - a[8]*a[2];
        adj[5] = -(a[0]*a[6] - a[4]*a[2]);
        adj[6] = a[4]*a[9] - a[8]*a[5];
        adj[7] = -(a[0]*a[9] - a[8]*a[1]);
        adj[8] = a[0]*a[5] - a[4]*a[1];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        adet = (det < 0) ? -det : det;
        if (adet <= ($signed({225'd0, floor_model}) <<< (2*amai_pkg::FRAC_BITS))) begin
            e = '{32'd0, 2'd0, 2'd0, 1'b1, 1'b1};
            expected_elems.push_back(e);
            return;
        end
        for (int k = 0; k < 9; k++) begin
            inv[k] = $signed(clamp_word(round_div(adj[k] <<< (2*amai_pkg::FRAC_BITS), det)));
            word[(k/3)*4 + k%3] = inv[k][31:0];
        end
        for (int r = 0; r < 3; r++) begin
            sum = -(a[3]*inv[r*3] + a[7]*inv[r*3+1] + a[11]*inv[r*3+2]);
            word[r*4+3] = clamp_word(sum < 0 ?
                -((-sum + (256'sd1 <<< (amai_pkg::FRAC_BITS-1))) >>> amai_pkg::FRAC_BITS) :
                ((sum + (256'sd1 <<< (amai_pkg::FRAC_BITS-1))) >>> amai_pkg::FRAC_BITS));
        end
        for (int i = 0; i < 12; i++) begin
            e = '{word[i], 2'(i/4), 2'(i%4), 1'b0, i == 11};
            expected_elems.push_back(e);
        end
    endtask

    function automatic logic [31:0] rand_entry(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8*65536)) - 4*65536);
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            default: return ($urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF);
        endcase
    endfunction

    // Mostly well-conditioned matrices near scaled identity, plus noise
    function automatic logic [amai_pkg::IN_TDATA_W-1:0] rand_matrix();
        logic [amai_pkg::IN_TDATA_W-1:0] m;
        int style;
        style = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) begin
            if (style < 6) begin
                m[i*32 +: 32] = rand_entry(1);
                if (i == 0 || i == 5 || i == 10)
                    m[i*32 +: 32] = 32'($signed($urandom_range(0, 1) ? 262144 : -262144)
                                        + $signed(m[i*32 +: 32]));
            end else if (style < 8) begin
                m[i*32 +: 32] = rand_entry(2);
            end else begin
                m[i*32 +: 32] = rand_entry($urandom_range(0, 3));
            end
        end
        // Occasionally make it rank deficient: row 2 copies row 0
        if ($urandom_range(0, 15) == 0) m[8*32 +: 96] = m[0 +: 96];
        return m;
    endfunction

    function automatic logic [amai_pkg::IN_TDATA_W-1:0] diag_matrix(logic [31:0] d,
                                                                    logic [31:0] t);
        logic [amai_pkg::IN_TDATA_W-1:0] m;
        m = '0;
        m[0 +: 32] = d; m[5*32 +: 32] = d; m[10*32 +: 32] = d;
        m[3*32 +: 32] = t; m[7*32 +: 32] = ~t; m[11*32 +: 32] = t;
        return m;
    endfunction

    // Sender: bursts with random gaps, items from the pending queue
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // hold the offered item
            end else if (!sender_paused && matrix_queue.size() > 0 && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= matrix_queue.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // Receiver: own stall pattern, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_sink) begin
            m_tready <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 2) begin
            stall_run <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Input acceptance, result checking and watchdog
    always @(posedge aclk) begin
        elem_t exp_e;
        bit progress;
        progress = 1'b0;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            predict_inverse(s_tdata);
            matrices_sent++;
            progress = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            progress = 1'b1;
            elems_seen++;
            if (m_tuser) singular_seen++;
            if (expected_elems.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_tdata);
            end else begin
                exp_e = expected_elems.pop_front();
                if (m_tdata[31:0] !== exp_e.value || m_tdata[33:32] !== exp_e.row ||
                    m_tdata[35:34] !== exp_e.col || m_tuser !== exp_e.sing ||
                    m_tlast !== exp_e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp v=%h r=%0d c=%0d s=%b l=%b, ",
                                  "got v=%h r=%0d c=%0d s=%b l=%b"},
                                 exp_e.value, exp_e.row, exp_e.col, exp_e.sing, exp_e.last,
                                 m_tdata[31:0], m_tdata[33:32], m_tdata[35:34],
                                 m_tuser, m_tlast);
                end
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("** affine_matrix_inverse_core: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (matrix_queue.size() > 0 || s_tvalid || expected_elems.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_floor(input logic [amai_pkg::FLOOR_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        floor_model = v;
    endtask

    initial begin
        logic [amai_pkg::IN_TDATA_W-1:0] m;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, scaled, extremes, zero, near-floor
        write_floor('0);
        matrix_queue.push_back(diag_matrix(32'h00010000, 32'h00012345));
        matrix_queue.push_back(diag_matrix(32'h00020000, 32'h80000000));
        matrix_queue.push_back(diag_matrix(32'hFFFF0000, 32'h7FFFFFFF));
        matrix_queue.push_back(diag_matrix(32'h00000001, 32'h00010000));
        matrix_queue.push_back(diag_matrix(32'h7FFFFFFF, 32'hFFFFFFFF));
        matrix_queue.push_back(diag_matrix(32'h80000000, 32'h00000001));
        matrix_queue.push_back('0);
        matrix_queue.push_back('1);
        m = '0;
        for (int i = 0; i < 12; i++) m[i*32 +: 32] = 32'h80000000;
        matrix_queue.push_back(m);
        for (int i = 0; i < 12; i++) m[i*32 +: 32] = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
        matrix_queue.push_back(m);
        for (int i = 0; i < 12; i++) m[i*32 +: 32] = 32'h55555555 ^ {32{i[0]}};
        matrix_queue.push_back(m);
        wait_drained();

        // Floor at exactly det = 1.0 gives singular; just above gives inverse
        write_floor(31'h00010000);
        matrix_queue.push_back(diag_matrix(32'h00010000, 32'h00010000));
        matrix_queue.push_back(diag_matrix(32'h00010001, 32'h00010000));
        wait_drained();

        // Long receiver hold while the sender keeps offering
        write_floor(31'd0);
        for (int i = 0; i < 40; i++) matrix_queue.push_back(rand_matrix());
        hold_sink = 1'b1;
        repeat (600) @(posedge aclk);
        hold_sink = 1'b0;
        wait_drained();

        // Random phases across floor settings, including the maximum
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_floor(31'd0);
                1: write_floor(31'($urandom_range(1, 32'h00020000)));
                2: write_floor(31'h7FFFFFFF);
                default: write_floor(31'd100);
            endcase
            for (int i = 0; i < ((phase == 2) ? 30 : 120); i++) begin
                matrix_queue.push_back(rand_matrix());
                if (i == 60) begin
                    while (matrix_queue.size() > 0 || s_tvalid) @(posedge aclk);
                    sender_paused = 1'b1;
                    while (expected_elems.size() > 0) @(posedge aclk);
                    sender_paused = 1'b0;
                end
            end
            wait_drained();
        end

        $display("covered %0d matrices, %0d result items, %0d singular",
                 matrices_sent, elems_seen, singular_seen);
        if (mismatches == 0) begin
            $display("** affine_matrix_inverse_core: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** affine_matrix_inverse_core: FAILED **");
        end
        $finish;
    end
endmodule
